// File: rtl/src_pkg.sv
// Shared types, codes and constants for the spiral route cipher.
package src_pkg;

   // Default grid limits handed to the top-level parameters
   localparam int MAX_COLS_DEF = 16;
   localparam int MAX_ROWS_DEF = 16;

   // Control/status port layout
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCKWISE = 2'd2;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] GRID_COLS_RST = 5'd9;
   localparam logic [CSR_DATA_W-1:0] GRID_ROWS_RST = 5'd3;
   localparam logic                  CLOCKWISE_RST = 1'b1;

   // Input word kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Character constants
   localparam logic [7:0] CH_X        = 8'h58;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_PERIOD   = 8'h2e;
   localparam logic [7:0] CH_COMMA    = 8'h2c;
   localparam logic [7:0] CH_BANG     = 8'h21;
   localparam logic [7:0] CH_QUESTION = 8'h3f;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic read;
   } cmd_type;

   // Status from datapath
   typedef struct packed {
      logic emitting;
      logic grid_full;
   } sts_type;

endpackage

// File: rtl/src_ctrl.sv
// Handshake controller: accepts words and sequences the response register.
module src_ctrl
   import src_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_kind,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // A new word may enter when idle or when the pending result leaves this cycle
   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign rsp_valid = (state_ff == ST_RESP);
   assign accept    = req_valid && req_ready;

   assign cmd.load = accept && (req_kind == KIND_LOAD);
   assign cmd.read = accept && (req_kind == KIND_READ);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.read) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (cmd.read)      state_in = ST_RESP;
            else if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/src_datapath.sv
// Datapath: config registers, grid store, fill count and spiral walker.
module src_datapath
   import src_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [7:0]             req_char_in,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output sts_type                sts,
   output logic [7:0]             rsp_char_out,
   output logic                   rsp_last_char
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RNW   = $clog2(MAX_ROWS + 1);
   localparam int CNW   = $clog2(MAX_COLS + 1);

   typedef enum logic [1:0] {
      HEAD_UP,
      HEAD_RIGHT,
      HEAD_DOWN,
      HEAD_LEFT
   } heading_type;

   // Config registers
   logic [CSR_DATA_W-1:0] cols_cfg_ff, cols_cfg_in;
   logic [CSR_DATA_W-1:0] rows_cfg_ff, rows_cfg_in;
   logic                  cw_ff, cw_in;

   // Control state
   logic          emitting_ff, emitting_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] emit_ff, emit_in;

   // Spiral walker state
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] top_ff, top_in;
   logic [RW-1:0] bottom_ff, bottom_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] right_ff, right_in;
   logic [AW-1:0] addr_ff, addr_in;
   heading_type   head_ff, head_in;

   // Grid store and result registers
   logic [7:0]    grid_mem [DEPTH];
   logic [7:0]    rdata_ff;
   logic          hit_ff;
   logic          last_ff;

   // Working signals
   logic [CNW-1:0] cols_eff;
   logic [RNW-1:0] rows_eff;
   logic [FW-1:0]  total;
   logic [7:0]     char_up;
   logic           dropped;
   logic           mem_we;
   logic [RW-1:0]  cur_row, cur_top, cur_bottom, nxt_row, nxt_top, nxt_bottom;
   logic [CW-1:0]  cur_col, cur_left, cur_right, nxt_col, nxt_left, nxt_right;
   logic [AW-1:0]  cur_addr, nxt_addr, step;
   logic [FW-1:0]  cur_emit;
   heading_type    cur_head, nxt_head;
   logic           blocked;
   logic           last;
   logic           hit;

   // Effective grid size: zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (cols_cfg_ff == '0)                cols_eff = CNW'(1);
      else if (int'(cols_cfg_ff) > MAX_COLS) cols_eff = CNW'(MAX_COLS);
      else                                  cols_eff = CNW'(cols_cfg_ff);
      if (rows_cfg_ff == '0)                rows_eff = RNW'(1);
      else if (int'(rows_cfg_ff) > MAX_ROWS) rows_eff = RNW'(MAX_ROWS);
      else                                  rows_eff = RNW'(rows_cfg_ff);
   end

   assign total = FW'(FW'(cols_eff) * FW'(rows_eff));
   assign step  = AW'(cols_eff);

   // Message filter and upper-casing
   assign dropped = (req_char_in == CH_SPACE) || (req_char_in == CH_PERIOD) ||
                    (req_char_in == CH_COMMA) || (req_char_in == CH_BANG) ||
                    (req_char_in == CH_QUESTION);
   assign char_up = ((req_char_in >= CH_LOWER_A) && (req_char_in <= CH_LOWER_Z)) ?
                    (req_char_in - CASE_OFFSET) : req_char_in;
   assign mem_we  = cmd.load && !emitting_ff && !dropped && (fill_ff < total);

   // Current walker position: top-right corner when a readout starts
   always_comb begin
      if (emitting_ff) begin
         cur_row    = row_ff;
         cur_col    = col_ff;
         cur_top    = top_ff;
         cur_bottom = bottom_ff;
         cur_left   = left_ff;
         cur_right  = right_ff;
         cur_addr   = addr_ff;
         cur_emit   = emit_ff;
         cur_head   = head_ff;
      end else begin
         cur_row    = '0;
         cur_col    = CW'(cols_eff - CNW'(1));
         cur_top    = '0;
         cur_bottom = RW'(rows_eff - RNW'(1));
         cur_left   = '0;
         cur_right  = CW'(cols_eff - CNW'(1));
         cur_addr   = AW'(cols_eff - CNW'(1));
         cur_emit   = '0;
         cur_head   = cw_ff ? HEAD_DOWN : HEAD_LEFT;
      end
   end

   assign last = ((FW+1)'(cur_emit) + (FW+1)'(1)) >= (FW+1)'(total);
   assign hit  = FW'(cur_addr) < fill_ff;

   // Leg end check: the next step would leave the current bounds
   always_comb begin
      case (cur_head)
         HEAD_UP:    blocked = (cur_row == cur_top);
         HEAD_RIGHT: blocked = (cur_col == cur_right);
         HEAD_DOWN:  blocked = (cur_row == cur_bottom);
         HEAD_LEFT:  blocked = (cur_col == cur_left);
         default:    blocked = 1'b0;
      endcase
   end

   // Finish a leg (shrink its bound, turn), then take one step
   always_comb begin
      nxt_top    = cur_top;
      nxt_bottom = cur_bottom;
      nxt_left   = cur_left;
      nxt_right  = cur_right;
      nxt_head   = cur_head;
      if (blocked) begin
         if (cw_ff) begin
            case (cur_head)
               HEAD_DOWN:  begin nxt_right  = cur_right - 1'b1;  nxt_head = HEAD_LEFT;  end
               HEAD_LEFT:  begin nxt_bottom = cur_bottom - 1'b1; nxt_head = HEAD_UP;    end
               HEAD_UP:    begin nxt_left   = cur_left + 1'b1;   nxt_head = HEAD_RIGHT; end
               HEAD_RIGHT: begin nxt_top    = cur_top + 1'b1;    nxt_head = HEAD_DOWN;  end
               default:    nxt_head = cur_head;
            endcase
         end else begin
            case (cur_head)
               HEAD_LEFT:  begin nxt_top    = cur_top + 1'b1;    nxt_head = HEAD_DOWN;  end
               HEAD_DOWN:  begin nxt_left   = cur_left + 1'b1;   nxt_head = HEAD_RIGHT; end
               HEAD_RIGHT: begin nxt_bottom = cur_bottom - 1'b1; nxt_head = HEAD_UP;    end
               HEAD_UP:    begin nxt_right  = cur_right - 1'b1;  nxt_head = HEAD_LEFT;  end
               default:    nxt_head = cur_head;
            endcase
         end
      end
      nxt_row  = cur_row;
      nxt_col  = cur_col;
      nxt_addr = cur_addr;
      case (nxt_head)
         HEAD_UP:    begin nxt_row = cur_row - 1'b1; nxt_addr = cur_addr - step;  end
         HEAD_RIGHT: begin nxt_col = cur_col + 1'b1; nxt_addr = cur_addr + 1'b1; end
         HEAD_DOWN:  begin nxt_row = cur_row + 1'b1; nxt_addr = cur_addr + step;  end
         HEAD_LEFT:  begin nxt_col = cur_col - 1'b1; nxt_addr = cur_addr - 1'b1; end
         default:    nxt_addr = cur_addr;
      endcase
   end

   // Next register values
   always_comb begin
      cols_cfg_in = cols_cfg_ff;
      rows_cfg_in = rows_cfg_ff;
      cw_in       = cw_ff;
      emitting_in = emitting_ff;
      fill_in     = fill_ff;
      emit_in     = emit_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      top_in      = top_ff;
      bottom_in   = bottom_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      addr_in     = addr_ff;
      head_in     = head_ff;

      if (mem_we) fill_in = fill_ff + 1'b1;

      if (cmd.read) begin
         if (last) begin
            emitting_in = 1'b0;
            fill_in     = '0;
            emit_in     = '0;
         end else begin
            emitting_in = 1'b1;
            emit_in     = cur_emit + 1'b1;
            row_in      = nxt_row;
            col_in      = nxt_col;
            top_in      = nxt_top;
            bottom_in   = nxt_bottom;
            left_in     = nxt_left;
            right_in    = nxt_right;
            addr_in     = nxt_addr;
            head_in     = nxt_head;
         end
      end

      // Register writes are dropped during a readout
      if (csr_we && !emitting_ff) begin
         case (csr_index)
            CSR_GRID_COLS: cols_cfg_in = csr_wdata;
            CSR_GRID_ROWS: rows_cfg_in = csr_wdata;
            CSR_CLOCKWISE: cw_in       = csr_wdata[0];
            default:       cw_in       = cw_ff;
         endcase
      end
   end

   // Control and walker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= GRID_COLS_RST;
         rows_cfg_ff <= GRID_ROWS_RST;
         cw_ff       <= CLOCKWISE_RST;
         emitting_ff <= 1'b0;
         fill_ff     <= '0;
         emit_ff     <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         top_ff      <= '0;
         bottom_ff   <= '0;
         left_ff     <= '0;
         right_ff    <= '0;
         addr_ff     <= '0;
         head_ff     <= HEAD_UP;
      end else begin
         cols_cfg_ff <= cols_cfg_in;
         rows_cfg_ff <= rows_cfg_in;
         cw_ff       <= cw_in;
         emitting_ff <= emitting_in;
         fill_ff     <= fill_in;
         emit_ff     <= emit_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         top_ff      <= top_in;
         bottom_ff   <= bottom_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
         addr_ff     <= addr_in;
         head_ff     <= head_in;
      end
   end

   // Grid store: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[fill_ff[AW-1:0]] <= char_up;
      if (cmd.read) rdata_ff <= grid_mem[cur_addr];
   end

   // Result flags travel with the read data
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         hit_ff  <= hit;
         last_ff <= last;
      end
   end

   assign rsp_char_out  = hit_ff ? rdata_ff : CH_X;
   assign rsp_last_char = last_ff;

   assign sts.emitting  = emitting_ff;
   assign sts.grid_full = (fill_ff >= total);

endmodule

// File: rtl/spiral_route_cipher_top.sv
// Top level of the spiral route cipher: controller, datapath and checks.
//
// Load words write one filtered, upper-cased message byte into the grid store.
// A read word returns the next grid character in spiral order; its result is
// valid the cycle after acceptance because the grid store's read data is
// registered. The next word is accepted in the same cycle its result is taken,
// so reads run at one word per cycle while the receiver keeps up, and while a
// result waits the input is stalled. No clearing pass is needed after reset: a
// fill count marks which cells hold message bytes. Register writes are ignored
// while a readout is in progress.
module spiral_route_cipher_top
   import src_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [7:0]             req_char_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_char_out,
   output logic                   rsp_last_char,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   src_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   src_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_char_in   (req_char_in),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .sts           (sts),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_char (rsp_last_char)
   );

   // A read word always yields a result word in the next cycle
   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_READ)) |=> rsp_valid)
      else $error("read word did not produce a result");

   // The final character ends the readout
   a_last_ends_readout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> !sts.emitting)
      else $error("readout still active after final character");

   // Any other character leaves the readout running
   a_mid_keeps_readout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_char) |-> sts.emitting)
      else $error("readout ended before final character");

   // A full grid ignores further loads
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (sts.grid_full && !sts.emitting && !(req_valid && req_ready &&
       (req_kind == KIND_READ)) && !csr_we) |=> sts.grid_full)
      else $error("grid lost its full state on a load");

endmodule
